// File: design/double_bank_priority_run_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Run queue assertion macros
// Shared macros for the concurrent checks of the run queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_BANK_PRIORITY_RUN_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_BANK_PRIORITY_RUN_QUEUE_TOP_DEFINES_SVH

`define DBPRQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("run queue check failed");

`define DBPRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("run queue check failed");

`endif

// File: design/dbprq_pkg.sv
// ----------------------------------------------------------------------------
// Run queue package
// Command and status codes, defaults and the timeslice table.
// ----------------------------------------------------------------------------
package dbprq_pkg;

  localparam int DEF_THREAD_SLOTS = 64;
  localparam int DEF_PRIO_LEVELS  = 13;

  localparam logic [3:0] CFG_RESET = 4'd11;

  localparam logic [2:0] CMD_WAKE    = 3'd0;
  localparam logic [2:0] CMD_REQUEUE = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_PICK    = 3'd3;
  localparam logic [2:0] CMD_INSERT  = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_PICKED = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  function automatic logic [2:0] slice_of(input int unsigned lvl);
    logic [2:0] s;
    priority if (lvl < 2) begin
      s = 3'd5;
    end else if (lvl < 5) begin
      s = 3'd4;
    end else if (lvl < 9) begin
      s = 3'd3;
    end else if (lvl < 11) begin
      s = 3'd2;
    end else begin
      s = 3'd1;
    end
    return s;
  endfunction

endpackage

// File: design/double_bank_priority_run_queue_top.sv
// ----------------------------------------------------------------------------
// Double bank priority run queue
// Active and pending banks of doubly linked per-priority thread queues.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start && !busy          command_i, thread_id_i, prio_i
// result    out        done_o (one cycle)      status_o ... queued_count_o
// config    in         cfg_we_i                cfg_wdata_i
//
// A wake, insert or requeue unlinks a queued thread (S_UL0 to S_UL2), then
// links it into the pending bank (S_P0 to S_P2); a remove only unlinks it. A
// pick scans one level per cycle from the cursor, then the other bank, and
// pops the first head found (S_PK); the result comes on the cycle after S_FIN.
// Reset empties every queue at once; the receiver cannot stall.
`include "double_bank_priority_run_queue_top_defines.svh"

module double_bank_priority_run_queue_top #(
  parameter int THREAD_SLOTS = dbprq_pkg::DEF_THREAD_SLOTS,
  parameter int PRIO_LEVELS  = dbprq_pkg::DEF_PRIO_LEVELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command_i,
  input  logic [5:0] thread_id_i,
  input  logic [3:0] prio_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [5:0] picked_thread_o,
  output logic [3:0] picked_prio_o,
  output logic [2:0] timeslice_o,
  output logic [6:0] queued_count_o
);
  import dbprq_pkg::*;

  localparam int TW = $clog2(THREAD_SLOTS);
  localparam int LW = TW + 1;
  localparam int PW = $clog2(PRIO_LEVELS);
  localparam int QN = 2 * PRIO_LEVELS;
  localparam int QW = $clog2(QN);
  localparam logic [LW-1:0] NIL = LW'(THREAD_SLOTS);
  localparam logic [PW-1:0] LAST_LVL = PW'(PRIO_LEVELS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UL0  = 4'd1;
  localparam logic [3:0] S_UL1  = 4'd2;
  localparam logic [3:0] S_UL2  = 4'd3;
  localparam logic [3:0] S_P0   = 4'd4;
  localparam logic [3:0] S_P1   = 4'd5;
  localparam logic [3:0] S_P2   = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_PK   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  function automatic logic [PW-1:0] sat_lvl(input logic [3:0] v);
    return (32'(v) >= PRIO_LEVELS) ? LAST_LVL : PW'(v);
  endfunction

  function automatic logic [QW-1:0] qidx(input logic b, input logic [PW-1:0] l);
    return b ? QW'(PRIO_LEVELS + 32'(l)) : QW'(l);
  endfunction

  logic [3:0]          state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [TW-1:0]       t_q, t_d;
  logic [PW-1:0]       ins_lvl_q, ins_lvl_d;
  logic [LW-1:0]       hsave_q, hsave_d;
  logic [QW-1:0]       qa_q, qa_d;
  logic                sb_q, sb_d;
  logic [PW-1:0]       sl_q, sl_d;
  logic                swapped_q, swapped_d;
  logic                active_q, active_d;
  logic [PW-1:0]       cursor_q, cursor_d;
  logic [6:0]          load_q, load_d;
  logic [3:0]          cfg_q;
  logic [THREAD_SLOTS-1:0] queued_q;
  logic [LW-1:0]       hd_q [QN];
  logic [LW-1:0]       tl_q [QN];
  logic [1:0]          status_q, status_d;
  logic [5:0]          pt_q, pt_d;
  logic [3:0]          pp_q, pp_d;
  logic [2:0]          ts_q, ts_d;
  logic                done_q, done_d;

  logic          hd_we, tl_we, q_set, q_clr;
  logic [LW-1:0] hd_wd, tl_wd;
  logic [TW-1:0] q_addr;
  logic          nx_we, pv_we, lb_we, rd_re, nx_re;
  logic [TW-1:0] nx_wa, pv_wa, nx_ra;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [PW:0]   lb_wd, lb_rd;

  logic          accept, tok;
  logic [PW-1:0] in_lvl, lim_lvl, rd_lvl, lvl_sel;
  logic          rd_bank;
  logic [LW-1:0] hd_cur, tl_cur;

  assign accept  = start && !busy;
  assign tok     = 32'(thread_id_i) < THREAD_SLOTS;
  assign lim_lvl = sat_lvl(cfg_q);
  assign in_lvl  = (command_i == CMD_WAKE && sat_lvl(prio_i) > lim_lvl) ? lim_lvl
                                                                         : sat_lvl(prio_i);
  assign rd_lvl  = lb_rd[PW-1:0];
  assign rd_bank = lb_rd[PW];
  assign lvl_sel = (cmd_q == CMD_REQUEUE) ? rd_lvl : ins_lvl_q;
  assign hd_cur  = hd_q[qa_q];
  assign tl_cur  = tl_q[qa_q];

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    t_d       = t_q;
    ins_lvl_d = ins_lvl_q;
    hsave_d   = hsave_q;
    qa_d      = qa_q;
    sb_d      = sb_q;
    sl_d      = sl_q;
    swapped_d = swapped_q;
    active_d  = active_q;
    cursor_d  = cursor_q;
    load_d    = load_q;
    status_d  = status_q;
    pt_d      = pt_q;
    pp_d      = pp_q;
    ts_d      = ts_q;
    done_d    = 1'b0;
    hd_we = 1'b0; hd_wd = NIL;
    tl_we = 1'b0; tl_wd = NIL;
    q_set = 1'b0; q_clr = 1'b0; q_addr = t_q;
    nx_we = 1'b0; nx_wa = t_q; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = t_q; pv_wd = NIL;
    lb_we = 1'b0; lb_wd = {~active_q, lvl_sel};
    rd_re = 1'b0; nx_re = 1'b0; nx_ra = t_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = command_i;
          t_d       = TW'(thread_id_i);
          ins_lvl_d = in_lvl;
          status_d  = ST_DONE;
          pt_d      = '0;
          pp_d      = '0;
          ts_d      = '0;
          rd_re     = 1'b1;
          nx_re     = 1'b1;
          nx_ra     = TW'(thread_id_i);
          if (tok && (command_i == CMD_WAKE || command_i == CMD_INSERT)) begin
            if (load_q != 7'd127) load_d = load_q + 7'd1;
          end else if (tok && command_i == CMD_REMOVE) begin
            if (load_q != 7'd0) load_d = load_q - 7'd1;
          end
          if (tok && (command_i == CMD_WAKE || command_i == CMD_INSERT ||
                      command_i == CMD_REQUEUE || command_i == CMD_REMOVE)) begin
            state_d = S_UL0;
          end else if (command_i == CMD_PICK) begin
            sb_d      = active_q;
            sl_d      = cursor_q;
            swapped_d = 1'b0;
            qa_d      = qidx(active_q, cursor_q);
            state_d   = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_UL0: begin
        if (queued_q[t_q]) begin
          qa_d    = qidx(rd_bank, rd_lvl);
          state_d = S_UL1;
        end else begin
          state_d = (cmd_q == CMD_REMOVE) ? S_FIN : S_P0;
        end
      end
      S_UL1: begin
        if (tl_cur == LW'(t_q)) begin
          tl_we = 1'b1;
          tl_wd = pv_rd;
        end
        if (hd_cur == LW'(t_q)) begin
          hd_we = 1'b1;
          hd_wd = nx_rd;
        end
        if (pv_rd != NIL) begin
          nx_we = 1'b1;
          nx_wa = pv_rd[TW-1:0];
          nx_wd = nx_rd;
        end
        state_d = S_UL2;
      end
      S_UL2: begin
        if (nx_rd != NIL) begin
          pv_we = 1'b1;
          pv_wa = nx_rd[TW-1:0];
          pv_wd = pv_rd;
        end
        q_clr   = 1'b1;
        state_d = (cmd_q == CMD_REMOVE) ? S_FIN : S_P0;
      end
      S_P0: begin
        qa_d    = qidx(~active_q, lvl_sel);
        lb_we   = 1'b1;
        state_d = S_P1;
      end
      S_P1: begin
        q_set = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (cmd_q == CMD_REQUEUE) begin
          pv_wd   = tl_cur;
          nx_wd   = NIL;
          tl_we   = 1'b1;
          tl_wd   = LW'(t_q);
          hd_we   = (tl_cur == NIL);
          hd_wd   = LW'(t_q);
          hsave_d = tl_cur;
        end else begin
          nx_wd   = hd_cur;
          pv_wd   = NIL;
          hd_we   = 1'b1;
          hd_wd   = LW'(t_q);
          tl_we   = (hd_cur == NIL);
          tl_wd   = LW'(t_q);
          hsave_d = hd_cur;
        end
        state_d = S_P2;
      end
      S_P2: begin
        if (hsave_q != NIL) begin
          if (cmd_q == CMD_REQUEUE) begin
            nx_we = 1'b1;
            nx_wa = hsave_q[TW-1:0];
            nx_wd = LW'(t_q);
          end else begin
            pv_we = 1'b1;
            pv_wa = hsave_q[TW-1:0];
            pv_wd = LW'(t_q);
          end
        end
        state_d = S_FIN;
      end
      S_SCAN: begin
        if (hd_cur != NIL) begin
          hsave_d = hd_cur;
          nx_re   = 1'b1;
          nx_ra   = hd_cur[TW-1:0];
          state_d = S_PK;
        end else if (sl_q == LAST_LVL) begin
          if (swapped_q) begin
            status_d = ST_NONE;
            state_d  = S_FIN;
          end else begin
            sb_d      = ~sb_q;
            sl_d      = '0;
            swapped_d = 1'b1;
            qa_d      = qidx(~sb_q, '0);
          end
        end else begin
          sl_d = sl_q + PW'(1);
          qa_d = qidx(sb_q, sl_q + PW'(1));
        end
      end
      S_PK: begin
        hd_we = 1'b1;
        hd_wd = nx_rd;
        if (tl_cur == hsave_q) begin
          tl_we = 1'b1;
          tl_wd = NIL;
        end
        if (nx_rd != NIL) begin
          pv_we = 1'b1;
          pv_wa = nx_rd[TW-1:0];
          pv_wd = NIL;
        end
        q_clr    = 1'b1;
        q_addr   = hsave_q[TW-1:0];
        active_d = sb_q;
        cursor_d = sl_q;
        status_d = ST_PICKED;
        pt_d     = 6'(hsave_q);
        pp_d     = 4'(sl_q);
        ts_d     = slice_of(32'(sl_q));
        state_d  = S_FIN;
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= 1'b0;
      cursor_q  <= '0;
      load_q    <= '0;
      cfg_q     <= CFG_RESET;
      queued_q  <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < QN; i++) begin
        hd_q[i] <= NIL;
        tl_q[i] <= NIL;
      end
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      cursor_q <= cursor_d;
      load_q   <= load_d;
      done_q   <= done_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (q_set) queued_q[q_addr] <= 1'b1;
      if (q_clr) queued_q[q_addr] <= 1'b0;
      if (hd_we) hd_q[qa_q] <= hd_wd;
      if (tl_we) tl_q[qa_q] <= tl_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    t_q       <= t_d;
    ins_lvl_q <= ins_lvl_d;
    hsave_q   <= hsave_d;
    qa_q      <= qa_d;
    sb_q      <= sb_d;
    sl_q      <= sl_d;
    swapped_q <= swapped_d;
    status_q  <= status_d;
    pt_q      <= pt_d;
    pp_q      <= pp_d;
    ts_q      <= ts_d;
  end

  dbprq_ram #(.W(LW), .D(THREAD_SLOTS)) u_next (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_wa),
    .wdata_i (nx_wd),
    .re_i    (nx_re),
    .raddr_i (nx_ra),
    .rdata_o (nx_rd)
  );

  dbprq_ram #(.W(LW), .D(THREAD_SLOTS)) u_prev (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_wa),
    .wdata_i (pv_wd),
    .re_i    (rd_re),
    .raddr_i (t_d),
    .rdata_o (pv_rd)
  );

  dbprq_ram #(.W(PW + 1), .D(THREAD_SLOTS)) u_level (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (t_q),
    .wdata_i (lb_wd),
    .re_i    (rd_re),
    .raddr_i (t_d),
    .rdata_o (lb_rd)
  );

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign picked_thread_o = pt_q;
  assign picked_prio_o   = pp_q;
  assign timeslice_o     = ts_q;
  assign queued_count_o  = load_q;

  `DBPRQ_ASSERT_SAME(a_done_idle, done_o, !busy)
  `DBPRQ_ASSERT_NEXT(a_start_busy, accept, busy)
  `DBPRQ_ASSERT_SAME(a_none_zero, done_o && status_o == ST_NONE, picked_thread_o == 6'd0)
  `DBPRQ_ASSERT_NEXT(a_load_hold, !accept, $stable(load_q))

endmodule

// File: design/dbprq_ram.sv
// ----------------------------------------------------------------------------
// Run queue link memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dbprq_ram #(
  parameter int W = 7,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sim/double_bank_priority_run_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run queue testbench
// Drives wake, insert, requeue, remove, pick and unused commands into the
// two-bank run queue, first from a short directed table, then at random, and
// checks each result against a table value or the testbench scheduler model.
// ----------------------------------------------------------------------------
module double_bank_priority_run_queue_top_tb;
  import dbprq_pkg::*;

  localparam int NSLOT = DEF_THREAD_SLOTS;
  localparam int NLVL = DEF_PRIO_LEVELS;
  localparam logic [6:0] NIL = 7'(NSLOT);
  localparam logic [2:0] CMD_NOP_LO = 3'd5;
  localparam logic [2:0] CMD_NOP_MID = 3'd6;
  localparam logic [2:0] CMD_NOP_HI = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] thread;
    logic [3:0] prio;
    logic [2:0] slice;
    logic [6:0] count;
  } sched_res_t;

  typedef struct {
    logic [2:0] cmd;
    logic [5:0] tid;
    logic [3:0] prio;
    bit         fixed;
    sched_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command_i = '0;
  logic [5:0] thread_id_i = '0;
  logic [3:0] prio_i = '0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic done_o;
  logic [1:0] status_o;
  logic [5:0] picked_thread_o;
  logic [3:0] picked_prio_o;
  logic [2:0] timeslice_o;
  logic [6:0] queued_count_o;

  double_bank_priority_run_queue_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .thread_id_i(thread_id_i), .prio_i(prio_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o),
    .status_o(status_o), .picked_thread_o(picked_thread_o),
    .picked_prio_o(picked_prio_o), .timeslice_o(timeslice_o),
    .queued_count_o(queued_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Scheduler model state.
  logic [6:0] nxt [NSLOT];
  logic [6:0] prv [NSLOT];
  logic [3:0] tlvl [NSLOT];
  bit         onq [NSLOT];
  bit         ever_ins [NSLOT];
  logic [6:0] qhead [2*NLVL];
  logic [6:0] qtail [2*NLVL];
  bit         cur_bank;
  logic [3:0] cursor;
  logic [6:0] load;
  logic [3:0] low_prio;

  sched_res_t pending_res [$];
  bit         use_fixed;
  sched_res_t fixed_res;
  int         errors;
  int         cycles;
  int         idle_pct;

  function automatic logic [3:0] clamp_lvl(logic [3:0] v);
    return (v >= NLVL) ? 4'(NLVL - 1) : v;
  endfunction

  function automatic logic [2:0] ticks_for(logic [3:0] l);
    logic [2:0] tbl [13];
    tbl = '{3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2,
            3'd1, 3'd1};
    return (l < 13) ? tbl[l] : 3'd1;
  endfunction

  function automatic void detach(int t);
    int q;
    for (int b = 0; b < 2; b++) begin
      q = b * NLVL + tlvl[t];
      if (qtail[q] == 7'(t)) qtail[q] = prv[t];
      if (qhead[q] == 7'(t)) qhead[q] = nxt[t];
    end
    if (prv[t] < NIL) nxt[prv[t]] = nxt[t];
    if (nxt[t] < NIL) prv[nxt[t]] = prv[t];
    nxt[t] = NIL;
    prv[t] = NIL;
    onq[t] = 0;
  endfunction

  function automatic void enqueue(int t, bit at_head);
    int q;
    q = (cur_bank ? 0 : 1) * NLVL + tlvl[t];
    if (at_head) begin
      nxt[t] = qhead[q];
      prv[t] = NIL;
      if (qhead[q] < NIL) prv[qhead[q]] = 7'(t);
      else qtail[q] = 7'(t);
      qhead[q] = 7'(t);
    end else begin
      prv[t] = qtail[q];
      nxt[t] = NIL;
      if (qtail[q] < NIL) nxt[qtail[q]] = 7'(t);
      else qhead[q] = 7'(t);
      qtail[q] = 7'(t);
    end
    onq[t] = 1;
  endfunction

  function automatic int first_level(bit b, int from);
    for (int l = from; l < NLVL; l++)
      if (qhead[b * NLVL + l] < NIL) return l;
    return -1;
  endfunction

  function automatic sched_res_t schedule(logic [2:0] cmd, logic [5:0] tid,
                                          logic [3:0] pr);
    sched_res_t r;
    logic [3:0] l, lim;
    bit b;
    int lv, q, h;
    r = '0;
    if (cmd == CMD_WAKE || cmd == CMD_INSERT) begin
      l = clamp_lvl(pr);
      lim = clamp_lvl(low_prio);
      if (cmd == CMD_WAKE && l > lim) l = lim;
      if (onq[tid]) detach(tid);
      tlvl[tid] = l;
      enqueue(tid, 1);
      if (load < 7'd127) load++;
    end else if (cmd == CMD_REQUEUE) begin
      if (onq[tid]) detach(tid);
      enqueue(tid, 0);
    end else if (cmd == CMD_REMOVE) begin
      if (onq[tid]) detach(tid);
      if (load > 0) load--;
    end else if (cmd == CMD_PICK) begin
      b = cur_bank;
      lv = first_level(b, cursor);
      if (lv < 0) begin
        b = ~b;
        lv = first_level(b, 0);
      end
      if (lv < 0) begin
        r.status = ST_NONE;
      end else begin
        q = b * NLVL + lv;
        h = qhead[q];
        cur_bank = b;
        cursor = 4'(lv);
        qhead[q] = nxt[h];
        if (qtail[q] == 7'(h)) qtail[q] = NIL;
        if (nxt[h] < NIL) prv[nxt[h]] = NIL;
        nxt[h] = NIL;
        prv[h] = NIL;
        onq[h] = 0;
        r.status = ST_PICKED;
        r.thread = 6'(h);
        r.prio = 4'(lv);
        r.slice = ticks_for(4'(lv));
      end
    end
    r.count = load;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      nxt[i] = NIL;
      prv[i] = NIL;
      tlvl[i] = '0;
      onq[i] = 0;
      ever_ins[i] = 0;
    end
    for (int i = 0; i < 2 * NLVL; i++) begin
      qhead[i] = NIL;
      qtail[i] = NIL;
    end
    cur_bank = 0;
    cursor = '0;
    load = '0;
    low_prio = CFG_RESET;
    use_fixed = 0;
    errors = 0;
    cycles = 0;
  end

  always @(posedge clk_i) begin
    sched_res_t e, r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with none expected", $time);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (status_o !== e.status || picked_thread_o !== e.thread ||
            picked_prio_o !== e.prio || timeslice_o !== e.slice ||
            queued_count_o !== e.count) begin
          $display("%0t: mismatch expected st=%0d th=%0d pr=%0d ts=%0d cnt=%0d",
                   $time, e.status, e.thread, e.prio, e.slice, e.count);
          $display("%0t: actual st=%0d th=%0d pr=%0d ts=%0d cnt=%0d", $time,
                   status_o, picked_thread_o, picked_prio_o, timeslice_o,
                   queued_count_o);
          errors++;
        end
      end
    end
    if (rst_ni && cfg_we_i) low_prio = cfg_wdata_i;
    if (rst_ni && start && !busy) begin
      r = schedule(command_i, thread_id_i, prio_i);
      pending_res.push_back(use_fixed ? fixed_res : r);
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [5:0] tid, logic [3:0] pr,
                           bit fixed, sched_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= cmd;
    thread_id_i <= tid;
    prio_i <= pr;
    use_fixed = fixed;
    fixed_res = res;
    do @(posedge clk_i); while (busy);
    if (cmd == CMD_WAKE || cmd == CMD_INSERT) ever_ins[tid] = 1;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [3:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item(bit narrow);
    int pick;
    logic [2:0] cmd;
    logic [5:0] tid;
    pick = $urandom_range(99);
    tid = narrow ? 6'($urandom_range(7)) : 6'($urandom);
    if (pick < 30) cmd = CMD_WAKE;
    else if (pick < 40) cmd = CMD_INSERT;
    else if (pick < 55) cmd = CMD_REQUEUE;
    else if (pick < 70) cmd = CMD_REMOVE;
    else if (pick < 95) cmd = CMD_PICK;
    else cmd = 3'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
    if (cmd == CMD_REQUEUE) begin
      // A requeue may only name a thread whose level has been set.
      for (int k = 0; k < 64 && !ever_ins[tid]; k++) tid = 6'($urandom);
      if (!ever_ins[tid]) cmd = CMD_WAKE;
    end
    send_item(cmd, tid, 4'($urandom), 0, '0);
  endtask

  dir_row_t dir_rows [] = '{
    '{CMD_PICK,    6'd0,  4'd0,  1, '{ST_NONE,   6'd0,  4'd0,  3'd0, 7'd0}},
    '{CMD_WAKE,    6'd63, 4'd15, 0, '0},
    '{CMD_INSERT,  6'd0,  4'd0,  0, '0},
    '{CMD_INSERT,  6'd5,  4'd15, 0, '0},
    '{CMD_PICK,    6'd0,  4'd0,  1, '{ST_PICKED, 6'd0,  4'd0,  3'd5, 7'd3}},
    '{CMD_PICK,    6'd0,  4'd0,  1, '{ST_PICKED, 6'd63, 4'd11, 3'd1, 7'd3}},
    '{CMD_PICK,    6'd0,  4'd0,  1, '{ST_PICKED, 6'd5,  4'd12, 3'd1, 7'd3}},
    '{CMD_PICK,    6'd0,  4'd0,  1, '{ST_NONE,   6'd0,  4'd0,  3'd0, 7'd3}},
    '{CMD_REQUEUE, 6'd63, 4'd0,  0, '0},
    '{CMD_REMOVE,  6'd63, 4'd0,  1, '{ST_DONE,   6'd0,  4'd0,  3'd0, 7'd2}},
    '{CMD_REMOVE,  6'd63, 4'd0,  1, '{ST_DONE,   6'd0,  4'd0,  3'd0, 7'd1}},
    '{CMD_REMOVE,  6'd0,  4'd0,  0, '0},
    '{CMD_REMOVE,  6'd5,  4'd0,  1, '{ST_DONE,   6'd0,  4'd0,  3'd0, 7'd0}},
    '{CMD_NOP_LO,  6'd1,  4'd1,  1, '{ST_DONE,   6'd0,  4'd0,  3'd0, 7'd0}},
    '{CMD_NOP_MID, 6'd2,  4'd2,  0, '0},
    '{CMD_NOP_HI,  6'd3,  4'd3,  0, '0},
    '{CMD_WAKE,    6'd10, 4'd3,  0, '0},
    '{CMD_WAKE,    6'd42, 4'd3,  0, '0},
    '{CMD_WAKE,    6'd21, 4'd7,  0, '0},
    '{CMD_REQUEUE, 6'd10, 4'd0,  0, '0},
    '{CMD_WAKE,    6'd42, 4'd9,  0, '0},
    '{CMD_PICK,    6'd0,  4'd0,  0, '0},
    '{CMD_INSERT,  6'd10, 4'd1,  0, '0},
    '{CMD_PICK,    6'd0,  4'd0,  0, '0},
    '{CMD_PICK,    6'd0,  4'd0,  0, '0}
  };

  initial begin
    logic [3:0] cfgs [6];
    cfgs = '{CFG_RESET, 4'd0, 4'd12, 4'd15, 4'($urandom), 4'd5};
    idle_pct = 32;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].tid, dir_rows[i].prio,
                dir_rows[i].fixed, dir_rows[i].res);
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 32 : (ph < 4) ? 73 : 0;
      if (ph > 0) write_cfg(cfgs[ph]);
      for (int i = 0; i < 305; i++) begin
        if (ph == 2 && i == 150) settle();
        random_item($urandom_range(1));
      end
    end
    settle();
    if (errors == 0 && pending_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/dbprq_pkg.sv
design/dbprq_ram.sv
design/double_bank_priority_run_queue_top.sv
sim/double_bank_priority_run_queue_top_tb.sv
